/* src/sfl_pkg.sv */
// Shared types and constants for the SPI frame link with reply queue.
// Used by spi_frame_link_with_reply_queue_core; depends on nothing else.
`timescale 1ns / 1ps
package sfl_pkg;

  // One input transfer.
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [3:0] name_index;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0]  miso_byte;
    logic [1:0]  frame_status;
    logic [7:0]  frame_kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] score_value;
    logic [7:0]  term_length;
    logic [2:0]  cursor;
    logic [2:0]  screen_page;
    logic        auto_light;
    logic        refresh;
    logic [7:0]  name_char;
  } out_t;

  // Receive phases, one-hot.
  typedef enum logic [3:0] {
    RX_IDLE = 4'b0001,
    RX_TYPE = 4'b0010,
    RX_DATA = 4'b0100,
    RX_SUM  = 4'b1000
  } rx_phase_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_X_LIMIT     = 2'd0;
  localparam logic [1:0] CFG_Y_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_SCORE_LIMIT = 2'd2;

  localparam logic [15:0] X_LIMIT_RST     = 16'd750;
  localparam logic [15:0] Y_LIMIT_RST     = 16'd430;
  localparam logic [15:0] SCORE_LIMIT_RST = 16'd999;
  localparam logic [15:0] POS_X_RST       = 16'd400;
  localparam logic [15:0] POS_Y_RST       = 16'd240;

  // Frame status codes.
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_RESET = 2'd3;

  // Frame types.
  localparam logic [7:0] FT_NAME_LO  = 8'd1;
  localparam logic [7:0] FT_NAME_HI  = 8'd5;
  localparam logic [7:0] FT_POS_X    = 8'd6;
  localparam logic [7:0] FT_POS_Y    = 8'd7;
  localparam logic [7:0] FT_TERM_LO  = 8'd8;
  localparam logic [7:0] FT_TERM_HI  = 8'd11;
  localparam logic [7:0] FT_SCORE    = 8'd13;
  localparam logic [7:0] FT_SOFT_RST = 8'd14;

  // Request codes held in the reply queue; zero marks an empty slot.
  localparam logic [4:0] REQ_NONE = 5'd0;
  localparam logic [4:0] REQ_DIR  = 5'd15;
  localparam logic [4:0] REQ_PICK = 5'd16;
  localparam logic [4:0] REQ_STOP = 5'd17;

  // Reply frame header and transmit phases.
  localparam logic [7:0] TX_HEADER   = 8'h03;
  localparam logic [2:0] TX_PH_HEAD  = 3'd1;
  localparam logic [2:0] TX_PH_CODE  = 3'd2;
  localparam logic [2:0] TX_PH_VALUE = 3'd3;

  // Screen event codes.
  localparam logic [7:0] EV_PAGE_LO  = 8'h31;
  localparam logic [7:0] EV_PAGE_HI  = 8'h34;
  localparam logic [7:0] EV_LIGHT_ON = 8'h35;
  localparam logic [7:0] EV_LIGHT_OF = 8'h36;
  localparam logic [7:0] EV_CUR_UP   = 8'h37;
  localparam logic [7:0] EV_CUR_DOWN = 8'h38;
  localparam logic [7:0] EV_PICK     = 8'h39;
  localparam logic [7:0] EV_SLEEP    = 8'h40;
  localparam logic [7:0] EV_HOME_LO  = 8'h41;
  localparam logic [7:0] EV_HOME_HI  = 8'h44;
  localparam logic [7:0] EV_LEFT     = 8'h51;
  localparam logic [7:0] EV_RIGHT    = 8'h52;
  localparam logic [7:0] EV_STOP     = 8'h53;
  localparam logic [7:0] EV_WAKE     = 8'h68;
  localparam logic [7:0] PAGE_BASE   = 8'h30;

  // Built-in program names, first character in the top byte, zero padded.
  localparam int INIT_COUNT = 5;
  localparam int INIT_LEN   = 10;
  localparam logic [79:0] INIT_NAMES [0:4] = '{
    80'("prgmDroite"),
    80'("prgmGauche"),
    {"prgmBleu", 16'h0000},
    {"prgmBlanc", 8'h00},
    {"prgmRouge", 8'h00}
  };

  // Reset character of a name slot; zero beyond the built-in table.
  function automatic logic [7:0] init_char(input int n, input int i);
    logic [7:0] c;
    c = 8'h00;
    if (n < INIT_COUNT && i < INIT_LEN) begin
      c = INIT_NAMES[n][79 - 8 * i -: 8];
    end
    return c;
  endfunction

endpackage

/* src/spi_frame_link_with_reply_queue_core.sv */
// Top level of the SPI frame link with reply queue: frame receiver, reply
// sender, screen event handling and the result register. Uses sfl_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------
//   in      | into core | in_valid / in_stall | sfl_pkg::in_t
//   out     | from core | out_valid/out_stall | sfl_pkg::out_t
//   cfg     | into core | cfg_we              | cfg_index, cfg_data
//
// Each item is one pass of logic from the state registers into the result
// register, and a new item can follow in each cycle while in_stall is low.
// The result appears in the cycle after the transfer in.
// rst is synchronous and loads the built-in names, limits and all link state; out_data is not reset.
// in_stall is raised only while a result is held and out_stall is high.
`timescale 1ns / 1ps
module spi_frame_link_with_reply_queue_core #(
  parameter int NAME_LEN    = 15,
  parameter int NAME_COUNT  = 5,
  parameter int QUEUE_DEPTH = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sfl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sfl_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  // Limits.
  logic [15:0] x_limit, y_limit, score_limit;

  // Link state and its next values.
  sfl_pkg::rx_phase_t rx_phase, rx_phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  payload [NAME_LEN];
  logic [7:0]  payload_next [NAME_LEN];
  logic [7:0]  names [NAME_COUNT][NAME_LEN];
  logic [7:0]  names_next [NAME_COUNT][NAME_LEN];
  logic [15:0] position_x, position_x_next;
  logic [15:0] position_y, position_y_next;
  logic [15:0] score_reg, score_reg_next;
  logic [7:0]  term_len, term_len_next;
  logic [2:0]  cursor_reg, cursor_reg_next;
  logic [2:0]  page_reg, page_reg_next;
  logic        light_reg, light_reg_next;
  logic        asleep, asleep_next;
  logic [4:0]  queue [QUEUE_DEPTH];
  logic [4:0]  queue_next [QUEUE_DEPTH];
  logic [QW-1:0] queue_rd, queue_rd_next;
  logic [QW-1:0] queue_wr, queue_wr_next;
  logic [2:0]  tx_phase, tx_phase_next;
  logic [7:0]  reply_value, reply_value_next;
  logic [1:0]  dir_req, dir_req_next;
  logic        stop_req, stop_req_next;

  logic          accept;
  sfl_pkg::out_t result;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // One item: a received byte and its reply byte, or a screen event; then the outputs.
  always_comb begin
    logic [7:0]  b;
    logic [7:0]  eff;
    logic [7:0]  cnt;
    logic [7:0]  pos;
    logic [15:0] word;
    logic [4:0]  code;
    logic [1:0]  status;
    logic [7:0]  miso;
    logic        redraw;
    logic [7:0]  nchar;

    b      = in_data.data_byte;
    status = sfl_pkg::ST_NONE;
    miso   = 8'h00;
    redraw = 1'b0;
    nchar  = 8'h00;
    eff    = (frame_length < 8'd2) ? 8'd2 : frame_length;
    cnt    = eff - 8'd2;
    pos    = byte_count - 8'd2;
    word   = {payload[0], payload[1]};
    code   = sfl_pkg::REQ_NONE;

    rx_phase_next     = rx_phase;
    frame_length_next = frame_length;
    frame_type_next   = frame_type;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    payload_next      = payload;
    names_next        = names;
    position_x_next   = position_x;
    position_y_next   = position_y;
    score_reg_next    = score_reg;
    term_len_next     = term_len;
    cursor_reg_next   = cursor_reg;
    page_reg_next     = page_reg;
    light_reg_next    = light_reg;
    asleep_next       = asleep;
    queue_next        = queue;
    queue_rd_next     = queue_rd;
    queue_wr_next     = queue_wr;
    tx_phase_next     = tx_phase;
    reply_value_next  = reply_value;
    dir_req_next      = dir_req;
    stop_req_next     = stop_req;

    if (!in_data.func) begin
      // Frame receiver.
      case (rx_phase)
        sfl_pkg::RX_IDLE: begin
          frame_length_next = b;
          if (b != 8'd0) rx_phase_next = sfl_pkg::RX_TYPE;
          running_sum_next = 8'd0;
          byte_count_next  = 8'd1;
        end
        sfl_pkg::RX_TYPE: begin
          frame_type_next = b;
          rx_phase_next   = (frame_length <= 8'd2) ? sfl_pkg::RX_SUM : sfl_pkg::RX_DATA;
          byte_count_next = byte_count + 8'd1;
        end
        sfl_pkg::RX_DATA: begin
          for (int i = 0; i < NAME_LEN; i++) begin
            if (byte_count >= 8'd2 && int'(pos) == i) payload_next[i] = b;
          end
          byte_count_next = byte_count + 8'd1;
          if (byte_count_next == frame_length) rx_phase_next = sfl_pkg::RX_SUM;
        end
        default: begin
          // Checksum byte: check and act on the frame.
          rx_phase_next = sfl_pkg::RX_IDLE;
          if (running_sum != b) begin
            status = sfl_pkg::ST_BAD;
          end else begin
            redraw = 1'b1;
            status = sfl_pkg::ST_OK;
            if (frame_type >= sfl_pkg::FT_NAME_LO && frame_type <= sfl_pkg::FT_NAME_HI) begin
              for (int n = 0; n < NAME_COUNT; n++) begin
                if (int'(frame_type) == n + 1) begin
                  for (int i = 0; i < NAME_LEN; i++) begin
                    names_next[n][i] = (i < int'(cnt)) ? payload[i] : 8'h00;
                  end
                end
              end
            end else if (frame_type == sfl_pkg::FT_POS_X) begin
              position_x_next = (word > x_limit) ? x_limit : word;
            end else if (frame_type == sfl_pkg::FT_POS_Y) begin
              position_y_next = (word > y_limit) ? y_limit : word;
            end else if (frame_type >= sfl_pkg::FT_TERM_LO &&
                         frame_type <= sfl_pkg::FT_TERM_HI) begin
              term_len_next = cnt;
            end else if (frame_type == sfl_pkg::FT_SCORE) begin
              score_reg_next = (word > score_limit) ? score_limit : word;
            end else if (frame_type == sfl_pkg::FT_SOFT_RST) begin
              // Soft reset: all link state back to its reset value.
              status            = sfl_pkg::ST_RESET;
              rx_phase_next     = sfl_pkg::RX_IDLE;
              frame_length_next = 8'd0;
              frame_type_next   = 8'd0;
              byte_count_next   = 8'd1;
              running_sum_next  = 8'd0;
              for (int i = 0; i < NAME_LEN; i++) payload_next[i] = 8'h00;
              for (int n = 0; n < NAME_COUNT; n++) begin
                for (int i = 0; i < NAME_LEN; i++) begin
                  names_next[n][i] = sfl_pkg::init_char(n, i);
                end
              end
              position_x_next  = sfl_pkg::POS_X_RST;
              position_y_next  = sfl_pkg::POS_Y_RST;
              score_reg_next   = 16'd0;
              term_len_next    = 8'd0;
              cursor_reg_next  = 3'd0;
              page_reg_next    = 3'd0;
              light_reg_next   = 1'b0;
              asleep_next      = 1'b0;
              for (int q = 0; q < QUEUE_DEPTH; q++) queue_next[q] = sfl_pkg::REQ_NONE;
              queue_rd_next    = '0;
              queue_wr_next    = '0;
              tx_phase_next    = 3'd0;
              reply_value_next = 8'd0;
              dir_req_next     = 2'd0;
              stop_req_next    = 1'b0;
            end
          end
        end
      endcase
      running_sum_next = running_sum_next + b;

      // Reply byte from the request at the head of the queue.
      code = queue_next[queue_rd_next];
      if (code != sfl_pkg::REQ_NONE) begin
        tx_phase_next = tx_phase_next + 3'd1;
        case (tx_phase_next)
          sfl_pkg::TX_PH_HEAD: miso = sfl_pkg::TX_HEADER;
          sfl_pkg::TX_PH_CODE: miso = {3'b000, code};
          sfl_pkg::TX_PH_VALUE: begin
            if (code == sfl_pkg::REQ_DIR) begin
              reply_value_next = {6'd0, dir_req_next};
              dir_req_next     = 2'd0;
            end else if (code == sfl_pkg::REQ_STOP) begin
              reply_value_next = {7'd0, stop_req_next};
              stop_req_next    = 1'b0;
            end else if (code == sfl_pkg::REQ_PICK) begin
              reply_value_next = {5'd0, cursor_reg_next};
            end
            miso = reply_value_next;
          end
          default: begin
            miso = reply_value_next + {3'b000, code} + sfl_pkg::TX_HEADER;
            queue_next[queue_rd_next] = sfl_pkg::REQ_NONE;
            queue_rd_next = (queue_rd_next == QW'(QUEUE_DEPTH - 1)) ? '0
                          : queue_rd_next + 1'b1;
            tx_phase_next    = 3'd0;
            reply_value_next = 8'd0;
          end
        endcase
      end
    end else if (asleep) begin
      // Asleep: only the wake event is heeded.
      if (b == sfl_pkg::EV_WAKE) begin
        asleep_next = 1'b0;
        redraw      = 1'b1;
      end
    end else begin
      // Screen events.
      case (b) inside
        [sfl_pkg::EV_PAGE_LO:sfl_pkg::EV_PAGE_HI]: begin
          page_reg_next = 3'(b - sfl_pkg::PAGE_BASE);
          redraw        = 1'b1;
        end
        [sfl_pkg::EV_HOME_LO:sfl_pkg::EV_HOME_HI]: begin
          page_reg_next = 3'd0;
          redraw        = 1'b1;
        end
        sfl_pkg::EV_LIGHT_ON: light_reg_next = 1'b1;
        sfl_pkg::EV_LIGHT_OF: light_reg_next = 1'b0;
        sfl_pkg::EV_CUR_UP: begin
          if (cursor_reg != 3'd0) begin
            cursor_reg_next = cursor_reg - 3'd1;
            redraw          = 1'b1;
          end
        end
        sfl_pkg::EV_CUR_DOWN: begin
          if ({1'b0, cursor_reg} + 4'd1 < 4'(NAME_COUNT)) begin
            cursor_reg_next = cursor_reg + 3'd1;
            redraw          = 1'b1;
          end
        end
        sfl_pkg::EV_PICK: begin
          queue_next[queue_wr] = sfl_pkg::REQ_PICK;
          queue_wr_next = (queue_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : queue_wr + 1'b1;
        end
        sfl_pkg::EV_SLEEP: asleep_next = 1'b1;
        sfl_pkg::EV_LEFT, sfl_pkg::EV_RIGHT: begin
          dir_req_next = (b == sfl_pkg::EV_LEFT) ? 2'd1 : 2'd2;
          queue_next[queue_wr] = sfl_pkg::REQ_DIR;
          queue_wr_next = (queue_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : queue_wr + 1'b1;
        end
        sfl_pkg::EV_STOP: begin
          stop_req_next = 1'b1;
          queue_next[queue_wr] = sfl_pkg::REQ_STOP;
          queue_wr_next = (queue_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : queue_wr + 1'b1;
        end
        default: ;
      endcase
    end

    // Character of the selected name after the update.
    for (int n = 0; n < NAME_COUNT; n++) begin
      for (int i = 0; i < NAME_LEN; i++) begin
        if (int'(cursor_reg_next) == n && int'(in_data.name_index) == i) begin
          nchar = names_next[n][i];
        end
      end
    end

    result.miso_byte    = miso;
    result.frame_status = status;
    result.frame_kind   = frame_type_next;
    result.pos_x        = position_x_next;
    result.pos_y        = position_y_next;
    result.score_value  = score_reg_next;
    result.term_length  = term_len_next;
    result.cursor       = cursor_reg_next;
    result.screen_page  = page_reg_next;
    result.auto_light   = light_reg_next;
    result.refresh      = redraw;
    result.name_char    = nchar;
  end

  // Limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit     <= sfl_pkg::X_LIMIT_RST;
      y_limit     <= sfl_pkg::Y_LIMIT_RST;
      score_limit <= sfl_pkg::SCORE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sfl_pkg::CFG_X_LIMIT:     x_limit     <= cfg_data;
        sfl_pkg::CFG_Y_LIMIT:     y_limit     <= cfg_data;
        sfl_pkg::CFG_SCORE_LIMIT: score_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Link state, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase     <= sfl_pkg::RX_IDLE;
      frame_length <= 8'd0;
      frame_type   <= 8'd0;
      byte_count   <= 8'd1;
      running_sum  <= 8'd0;
      for (int i = 0; i < NAME_LEN; i++) payload[i] <= 8'h00;
      for (int n = 0; n < NAME_COUNT; n++) begin
        for (int i = 0; i < NAME_LEN; i++) names[n][i] <= sfl_pkg::init_char(n, i);
      end
      position_x  <= sfl_pkg::POS_X_RST;
      position_y  <= sfl_pkg::POS_Y_RST;
      score_reg   <= 16'd0;
      term_len    <= 8'd0;
      cursor_reg  <= 3'd0;
      page_reg    <= 3'd0;
      light_reg   <= 1'b0;
      asleep      <= 1'b0;
      for (int q = 0; q < QUEUE_DEPTH; q++) queue[q] <= sfl_pkg::REQ_NONE;
      queue_rd    <= '0;
      queue_wr    <= '0;
      tx_phase    <= 3'd0;
      reply_value <= 8'd0;
      dir_req     <= 2'd0;
      stop_req    <= 1'b0;
    end else if (accept) begin
      rx_phase     <= rx_phase_next;
      frame_length <= frame_length_next;
      frame_type   <= frame_type_next;
      byte_count   <= byte_count_next;
      running_sum  <= running_sum_next;
      payload      <= payload_next;
      names        <= names_next;
      position_x   <= position_x_next;
      position_y   <= position_y_next;
      score_reg    <= score_reg_next;
      term_len     <= term_len_next;
      cursor_reg   <= cursor_reg_next;
      page_reg     <= page_reg_next;
      light_reg    <= light_reg_next;
      asleep       <= asleep_next;
      queue        <= queue_next;
      queue_rd     <= queue_rd_next;
      queue_wr     <= queue_wr_next;
      tx_phase     <= tx_phase_next;
      reply_value  <= reply_value_next;
      dir_req      <= dir_req_next;
      stop_req     <= stop_req_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data <= result;
  end

  // Checks on the link logic.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transfer produced no result");

  a_queue_ptr_range: assert property (@(posedge clk) disable iff (rst)
    int'(queue_rd) < QUEUE_DEPTH && int'(queue_wr) < QUEUE_DEPTH)
    else $error("queue pointer beyond depth");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    int'(cursor_reg) < NAME_COUNT)
    else $error("cursor beyond name count");

  a_tx_phase_range: assert property (@(posedge clk) disable iff (rst)
    tx_phase <= sfl_pkg::TX_PH_VALUE)
    else $error("transmit phase beyond value byte");

  a_soft_reset_redraw: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_status == sfl_pkg::ST_RESET |-> out_data.refresh)
    else $error("soft reset without redraw");

endmodule
